### rtl/core/stt_pkg.sv
// stt_pkg: shared types and constants for the source text tokenizer
// no dependencies
`default_nettype none
package stt_pkg;
  typedef enum logic [5:0] {
    K_KW_VAL = 6'd0, K_KW_VAR, K_KW_FN, K_KW_RETURN, K_KW_IF, K_KW_ELSE, K_KW_WHILE,
    K_KW_FOR, K_KW_IN, K_KW_TRUE, K_KW_FALSE, K_KW_PRINTLN, K_KW_INT, K_KW_FLOAT,
    K_KW_BOOL, K_KW_STRING,
    K_PLUS = 6'd16, K_MINUS, K_STAR, K_SLASH, K_PERCENT, K_ASSIGN, K_EQ, K_NE, K_LT,
    K_GT, K_LE, K_GE, K_AND, K_OR, K_NOT, K_ARROW, K_RANGE, K_LPAREN, K_RPAREN,
    K_LBRACE, K_RBRACE, K_LBRACK, K_RBRACK, K_COLON, K_COMMA,
    K_INT = 6'd41, K_FLOAT, K_STR, K_IDENT, K_EOF, K_ERROR
  } kind_e;

  typedef enum logic [2:0] {
    E_NONE = 3'd0, E_AMP = 3'd1, E_BAR = 3'd2, E_DOT = 3'd3, E_UNKNOWN = 3'd4,
    E_STR_NL = 3'd5, E_STR_END = 3'd6, E_COM_END = 3'd7
  } err_e;

  typedef enum logic [3:0] {
    M_IDLE, M_OP, M_SLASH, M_IDENT, M_NUM, M_NUM_DOT, M_FLOAT, M_STR,
    M_LCOM, M_BCOM, M_BCOM_STAR
  } mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_col;
    logic [31:0] start_offset;
    logic [15:0] lexeme_len;
    logic [2:0]  error_code;
    logic [7:0]  bad_char;
    logic        error_flag;
    logic        last;
  } out_item_t;

  function automatic logic is_alpha(input logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    return (l >= "a" && l <= "z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // keyword lookup on a right-aligned window of up to seven bytes
  function automatic logic [5:0] word_kind(input logic [55:0] w, input logic [3:0] n);
    logic [5:0] k;
    k = K_IDENT;
    case (n)
      4'd2: begin
        if (w[15:0] == "fn") k = K_KW_FN;
        else if (w[15:0] == "if") k = K_KW_IF;
        else if (w[15:0] == "in") k = K_KW_IN;
      end
      4'd3: begin
        if (w[23:0] == "val") k = K_KW_VAL;
        else if (w[23:0] == "var") k = K_KW_VAR;
        else if (w[23:0] == "for") k = K_KW_FOR;
        else if (w[23:0] == "int") k = K_KW_INT;
      end
      4'd4: begin
        if (w[31:0] == "else") k = K_KW_ELSE;
        else if (w[31:0] == "true") k = K_KW_TRUE;
        else if (w[31:0] == "bool") k = K_KW_BOOL;
      end
      4'd5: begin
        if (w[39:0] == "while") k = K_KW_WHILE;
        else if (w[39:0] == "false") k = K_KW_FALSE;
        else if (w[39:0] == "float") k = K_KW_FLOAT;
      end
      4'd6: begin
        if (w[47:0] == "return") k = K_KW_RETURN;
        else if (w[47:0] == "string") k = K_KW_STRING;
      end
      4'd7: begin
        if (w[55:0] == "println") k = K_KW_PRINTLN;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction
endpackage
`default_nettype wire

### rtl/core/stt_fifo.sv
// stt_fifo: small synchronous queue of result items
// depends on stt_pkg
`default_nettype none
module stt_fifo #(
  parameter int unsigned Depth = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  stt_pkg::out_item_t  wdata_i,
  input  logic                rd_i,
  output stt_pkg::out_item_t  rdata_o,
  output logic                empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);
  import stt_pkg::*;
  localparam int unsigned AW = $clog2(Depth);
  out_item_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [$clog2(Depth+1)-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (rd_i) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (wr_i ? 1'b1 : 1'b0) - (rd_i ? 1'b1 : 1'b0);
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Depth)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_i |-> !empty_o)
    else $error("read from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (wr_i && !rd_i) |=> cnt_q != '0)
    else $error("count lost a write");
`endif
endmodule
`default_nettype wire

### rtl/core/stt_scan.sv
// stt_scan: the scanner state machine, one byte per cycle, up to three results
// depends on stt_pkg
`default_nettype none
module stt_scan #(
  parameter int unsigned CoordBits  = 16,
  parameter int unsigned OffsetBits = 32,
  parameter int unsigned LenBits    = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  stt_pkg::in_item_t     item_i,
  output logic [1:0]            n_o,
  output stt_pkg::out_item_t    res_o [3]
);
  import stt_pkg::*;
  localparam logic [CoordBits-1:0]  CMax = '1;
  localparam logic [OffsetBits-1:0] OMax = '1;
  localparam logic [LenBits-1:0]    LMax = '1;
  // internal markers: byte opened a token or was whitespace, byte matched nothing
  localparam logic [5:0] KOpened  = 6'd62;
  localparam logic [5:0] KNoMatch = 6'd63;

  mode_e mode_q, mode_d;
  logic [7:0] pend_q, pend_d;
  logic [CoordBits-1:0] tline_q, tline_d, tcol_q, tcol_d, cline_q, cline_d, ccol_q, ccol_d;
  logic [CoordBits-1:0] dcol_q, dcol_d;
  logic [OffsetBits-1:0] toff_q, toff_d, coff_q, coff_d, doff_q, doff_d;
  logic [LenBits-1:0] tlen_q, tlen_d;
  logic [55:0] win_q, win_d;
  logic err_q, err_d;

  out_item_t r [3];
  logic [1:0] n;

  function automatic logic [15:0] c16(input logic [CoordBits-1:0] v);
    return 16'(v);
  endfunction

  // combinational emission helpers work on locals declared below
  always_comb begin
    logic [7:0] c;
    logic done, disp;
    logic [5:0] k;
    logic [5:0] pk;
    logic [7:0] pb;
    logic [CoordBits-1:0] pl, pc;
    logic [OffsetBits-1:0] po;
    c = item_i.ch;
    mode_d = mode_q; pend_d = pend_q; tline_d = tline_q; tcol_d = tcol_q;
    cline_d = cline_q; ccol_d = ccol_q; toff_d = toff_q; coff_d = coff_q;
    dcol_d = dcol_q; doff_d = doff_q; tlen_d = tlen_q; win_d = win_q; err_d = err_q;
    n = 2'd0;
    for (int i = 0; i < 3; i++) r[i] = '0;
    done = 1'b0; disp = 1'b0; k = '0;
    pk = '0; pb = '0; pl = '0; pc = '0; po = '0;

    if (valid_i) begin
      if (item_i.is_end) begin
        // flush whatever token is open
        case (mode_q)
          M_OP: begin
            disp = 1'b1; pb = pend_q;
          end
          M_SLASH: begin
            r[0] = '{K_SLASH, c16(tline_q), c16(tcol_q), 32'(toff_q), 16'd1, E_NONE,
                     8'd0, err_d, 1'b0};
            n = 2'd1;
          end
          M_IDENT: begin
            r[0] = '{(tlen_q > LenBits'(7)) ? K_IDENT : word_kind(win_q, 4'(tlen_q)),
                     c16(tline_q), c16(tcol_q), 32'(toff_q), 16'(tlen_q), E_NONE, 8'd0,
                     err_d, 1'b0};
            n = 2'd1;
          end
          M_NUM, M_FLOAT: begin
            r[0] = '{(mode_q == M_NUM) ? K_INT : K_FLOAT, c16(tline_q), c16(tcol_q),
                     32'(toff_q), 16'(tlen_q), E_NONE, 8'd0, err_d, 1'b0};
            n = 2'd1;
          end
          M_NUM_DOT: begin
            err_d = 1'b1;
            r[0] = '{K_INT, c16(tline_q), c16(tcol_q), 32'(toff_q), 16'(tlen_q), E_NONE,
                     8'd0, err_q, 1'b0};
            r[1] = '{K_ERROR, c16(cline_q), c16(dcol_q), 32'(doff_q), 16'd1, E_DOT, ".",
                     1'b1, 1'b0};
            n = 2'd2;
          end
          M_STR: begin
            err_d = 1'b1;
            r[0] = '{K_ERROR, c16(tline_q), c16(tcol_q), 32'(toff_q), 16'd0, E_STR_END,
                     8'd0, 1'b1, 1'b0};
            n = 2'd1;
          end
          M_BCOM, M_BCOM_STAR: begin
            err_d = 1'b1;
            r[0] = '{K_ERROR, c16(tline_q), c16(tcol_q), 32'(toff_q), 16'd0, E_COM_END,
                     8'd0, 1'b1, 1'b0};
            n = 2'd1;
          end
          default: ;
        endcase
        if (disp) begin
          // single operator or stray byte at end
          case (pb)
            "-": pk = K_MINUS;
            "=": pk = K_ASSIGN;
            "!": pk = K_NOT;
            "<": pk = K_LT;
            ">": pk = K_GT;
            default: pk = K_ERROR;
          endcase
          if (pk == K_ERROR) err_d = 1'b1;
          r[0] = '{pk, c16(tline_q), c16(tcol_q), 32'(toff_q), 16'd1,
                   (pk != K_ERROR) ? E_NONE : (pb == "&") ? E_AMP : (pb == "|") ? E_BAR :
                   (pb == ".") ? E_DOT : E_UNKNOWN,
                   (pk == K_ERROR) ? pb : 8'd0, err_d, 1'b0};
          n = 2'd1;
        end
        r[n] = '{K_EOF, c16(cline_q), c16(ccol_q), 32'(coff_q), 16'd0, E_NONE, 8'd0,
                 err_d, 1'b1};
        n = n + 2'd1;
        mode_d = M_IDLE; pend_d = '0;
        tline_d = CoordBits'(1); tcol_d = CoordBits'(1); toff_d = '0;
        cline_d = CoordBits'(1); ccol_d = CoordBits'(1); coff_d = '0;
        tlen_d = '0; win_d = '0; dcol_d = '0; doff_d = '0;
      end else begin
        // stage 1: leave the current mode; disp set when the byte starts afresh
        pl = tline_q; pc = tcol_q; po = toff_q; pb = pend_q;
        case (mode_q)
          M_IDLE: disp = 1'b1;
          M_OP: done = 1'b1;
          M_SLASH: begin
            if (c == "/") mode_d = M_LCOM;
            else if (c == "*") mode_d = M_BCOM;
            else begin
              r[0] = '{K_SLASH, c16(tline_q), c16(tcol_q), 32'(toff_q), 16'd1, E_NONE,
                       8'd0, err_q, 1'b0};
              n = 2'd1; disp = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
              tlen_d = (tlen_q == LMax) ? tlen_q : tlen_q + 1'b1;
              win_d = {win_q[47:0], c};
            end else begin
              r[0] = '{(tlen_q > LenBits'(7)) ? K_IDENT : word_kind(win_q, 4'(tlen_q)),
                       c16(tline_q), c16(tcol_q), 32'(toff_q), 16'(tlen_q), E_NONE, 8'd0,
                       err_q, 1'b0};
              n = 2'd1; disp = 1'b1;
            end
          end
          M_NUM, M_FLOAT: begin
            if (is_digit(c)) begin
              tlen_d = (tlen_q == LMax) ? tlen_q : tlen_q + 1'b1;
              win_d = {win_q[47:0], c};
            end else if (c == "." && mode_q == M_NUM) begin
              dcol_d = ccol_q; doff_d = coff_q; mode_d = M_NUM_DOT;
            end else begin
              r[0] = '{(mode_q == M_NUM) ? K_INT : K_FLOAT, c16(tline_q), c16(tcol_q),
                       32'(toff_q), 16'(tlen_q), E_NONE, 8'd0, err_q, 1'b0};
              n = 2'd1; disp = 1'b1;
            end
          end
          M_NUM_DOT: begin
            if (is_digit(c)) begin
              tlen_d = (tlen_q == LMax) ? tlen_q :
                       (tlen_q == LMax - 1'b1) ? LMax : tlen_q + LenBits'(2);
              win_d = {win_q[39:0], 8'h2e, c};
              mode_d = M_FLOAT;
            end else begin
              r[0] = '{K_INT, c16(tline_q), c16(tcol_q), 32'(toff_q), 16'(tlen_q), E_NONE,
                       8'd0, err_q, 1'b0};
              n = 2'd1;
              pb = "."; pl = cline_q; pc = dcol_q; po = doff_q;
              tline_d = cline_q; tcol_d = dcol_q; toff_d = doff_q;
              done = 1'b1;
            end
          end
          M_STR: begin
            if (c == "\"") begin
              r[0] = '{K_STR, c16(tline_q), c16(tcol_q),
                       32'((toff_q == OMax) ? toff_q : toff_q + 1'b1), 16'(tlen_q), E_NONE,
                       8'd0, err_q, 1'b0};
              n = 2'd1; mode_d = M_IDLE;
            end else if (c == 8'h0a) begin
              err_d = 1'b1;
              r[0] = '{K_ERROR, c16(cline_q), c16(ccol_q), 32'(coff_q), 16'd0, E_STR_NL,
                       8'd0, 1'b1, 1'b0};
              n = 2'd1; mode_d = M_IDLE;
            end else begin
              tlen_d = (tlen_q == LMax) ? tlen_q : tlen_q + 1'b1;
            end
          end
          M_LCOM: if (c == 8'h0a) mode_d = M_IDLE;
          M_BCOM: if (c == "*") mode_d = M_BCOM_STAR;
          M_BCOM_STAR: begin
            if (c == "/") mode_d = M_IDLE;
            else if (c != "*") mode_d = M_BCOM;
          end
          default: disp = 1'b1;
        endcase
        // stage 2: pending operator meets this byte
        if (done) begin
          k = KNoMatch;
          if (pb == "-" && c == ">") k = K_ARROW;
          else if (c == "=" && pb == "=") k = K_EQ;
          else if (c == "=" && pb == "!") k = K_NE;
          else if (c == "=" && pb == "<") k = K_LE;
          else if (c == "=" && pb == ">") k = K_GE;
          else if (pb == "&" && c == "&") k = K_AND;
          else if (pb == "|" && c == "|") k = K_OR;
          else if (pb == "." && c == ".") k = K_RANGE;
          if (k != KNoMatch) begin
            r[n] = '{k, c16(pl), c16(pc), 32'(po), 16'd2, E_NONE, 8'd0, err_d, 1'b0};
            n = n + 2'd1; mode_d = M_IDLE;
          end else begin
            case (pb)
              "-": pk = K_MINUS;
              "=": pk = K_ASSIGN;
              "!": pk = K_NOT;
              "<": pk = K_LT;
              ">": pk = K_GT;
              default: pk = K_ERROR;
            endcase
            if (pk == K_ERROR) err_d = 1'b1;
            r[n] = '{pk, c16(pl), c16(pc), 32'(po), 16'd1,
                     (pk != K_ERROR) ? E_NONE : (pb == "&") ? E_AMP : (pb == "|") ? E_BAR :
                     (pb == ".") ? E_DOT : E_UNKNOWN,
                     (pk == K_ERROR) ? pb : 8'd0, err_d, 1'b0};
            n = n + 2'd1; disp = 1'b1;
          end
        end
        // stage 3: dispatch of a fresh byte
        if (disp) begin
          mode_d = M_IDLE;
          k = KNoMatch;
          if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
            k = KOpened;
          end else if (c == "/" || is_alpha(c) || is_digit(c) || c == "\"") begin
            k = KOpened;
            tline_d = cline_q; tcol_d = ccol_q; toff_d = coff_q;
            tlen_d = (c == "/" || c == "\"") ? '0 : LenBits'(1);
            win_d = (c == "/" || c == "\"") ? '0 : {48'd0, c};
            mode_d = (c == "/") ? M_SLASH : (c == "\"") ? M_STR :
                     is_digit(c) ? M_NUM : M_IDENT;
          end else begin
            case (c)
              "+": k = K_PLUS;
              "*": k = K_STAR;
              "%": k = K_PERCENT;
              "(": k = K_LPAREN;
              ")": k = K_RPAREN;
              "{": k = K_LBRACE;
              "}": k = K_RBRACE;
              "[": k = K_LBRACK;
              "]": k = K_RBRACK;
              ":": k = K_COLON;
              ",": k = K_COMMA;
              "-", "=", "!", "<", ">", "&", "|", ".": begin
                k = KOpened;
                tline_d = cline_q; tcol_d = ccol_q; toff_d = coff_q;
                tlen_d = '0; win_d = '0; mode_d = M_OP; pend_d = c;
              end
              default: k = KNoMatch;
            endcase
          end
          if (k != KOpened) begin
            if (k == KNoMatch) err_d = 1'b1;
            r[n] = '{(k == KNoMatch) ? K_ERROR : k, c16(cline_q), c16(ccol_q), 32'(coff_q),
                     16'd1, (k == KNoMatch) ? E_UNKNOWN : E_NONE,
                     (k == KNoMatch) ? c : 8'd0, err_d, 1'b0};
            n = n + 2'd1;
          end
        end
        if (c == 8'h0a) begin
          cline_d = (cline_q == CMax) ? cline_q : cline_q + 1'b1;
          ccol_d = CoordBits'(1);
        end else begin
          ccol_d = (ccol_q == CMax) ? ccol_q : ccol_q + 1'b1;
        end
        coff_d = (coff_q == OMax) ? coff_q : coff_q + 1'b1;
        if (n != 2'd0) r[n - 2'd1].last = 1'b1;
      end
    end
  end

  assign n_o = n;
  assign res_o = r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; pend_q <= '0; err_q <= 1'b0;
      tline_q <= CoordBits'(1); tcol_q <= CoordBits'(1); toff_q <= '0;
      cline_q <= CoordBits'(1); ccol_q <= CoordBits'(1); coff_q <= '0;
      tlen_q <= '0; win_q <= '0; dcol_q <= '0; doff_q <= '0;
    end else begin
      mode_q <= mode_d; pend_q <= pend_d; err_q <= err_d;
      tline_q <= tline_d; tcol_q <= tcol_d; toff_q <= toff_d;
      cline_q <= cline_d; ccol_q <= ccol_d; coff_q <= coff_d;
      tlen_q <= tlen_d; win_q <= win_d; dcol_q <= dcol_d; doff_q <= doff_d;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni) $past(err_q) |-> err_q)
    else $error("sticky error flag dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cline_q != '0 && ccol_q != '0)
    else $error("line or column reached zero");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && item_i.is_end) |=> (mode_q == M_IDLE && coff_q == '0))
    else $error("end marker did not restart scan");
`endif
endmodule
`default_nettype wire

### rtl/core/source_text_tokenizer_unit.sv
// source_text_tokenizer_unit: top level, scanner front end and result queue back end
// depends on stt_pkg, stt_scan, stt_fifo
//
// channel  | direction | handshake   | payload
// input    | in        | push, full  | in_item_i   (ch, is_end)
// result   | out       | pop, empty  | out_item_o  (token and error fields)
//
// a byte is taken at any edge with push high and full low; it yields zero to three results
// those results land in a three-entry staging row that moves one per cycle into an
//   eight-entry queue, drained one per cycle by pop
// full is high while the row still holds two or more results, or while row and queue
//   together hold more than five; so a byte with two or three results holds the input
//   until one result is left in the row, and bytes with at most one result go back to back
// a byte's results pass through the staging row register into the queue before a pop
// reset clears scan state, counters, the sticky error flag and the queue
`default_nettype none
module source_text_tokenizer_unit #(
  parameter int unsigned COORD_BITS  = 16,
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned LEN_BITS    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  stt_pkg::in_item_t   in_item_i,
  output logic                empty,
  input  logic                pop,
  output stt_pkg::out_item_t  out_item_o
);
  import stt_pkg::*;
  localparam int unsigned QDepth = 8;
  localparam int unsigned CW = $clog2(QDepth + 1);

  logic [1:0] n;
  out_item_t res [3];
  out_item_t q_wdata;
  logic [CW-1:0] cnt;
  logic acc;

  // the scanner makes up to three results per byte; a staging row holds them and feeds
  // the queue one result per cycle
  out_item_t   stage_q [3];
  logic [1:0]  stage_n_q, stage_rd_q;
  logic [1:0]  stage_n_d, stage_rd_d;
  logic        q_wr, q_rd;
  logic [CW-1:0] pend_cnt;

  assign acc = push && !full;

  stt_scan #(
    .CoordBits(COORD_BITS), .OffsetBits(OFFSET_BITS), .LenBits(LEN_BITS)
  ) u_scan (
    .clk_i, .rst_ni, .valid_i(acc), .item_i(in_item_i), .n_o(n), .res_o(res)
  );

  // staging row: holds one byte's results, drained one per cycle into the queue
  always_comb begin
    stage_n_d = stage_n_q;
    stage_rd_d = stage_rd_q;
    q_wr = (stage_rd_q != stage_n_q);
    q_wdata = stage_q[stage_rd_q];
    if (q_wr) stage_rd_d = stage_rd_q + 1'b1;
    if (acc) begin
      stage_n_d = n;
      stage_rd_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) stage_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_n_q <= '0; stage_rd_q <= '0;
    end else begin
      stage_n_q <= stage_n_d; stage_rd_q <= stage_rd_d;
    end
  end

  // a new byte may enter only when the staging row is empty or drains this cycle and room remains
  assign pend_cnt = cnt + CW'(stage_n_q - stage_rd_q);
  assign full = ((stage_n_q - stage_rd_q) > 2'd1) || (pend_cnt > CW'(QDepth - 3));
  assign q_rd = pop && !empty;

  stt_fifo #(.Depth(QDepth)) u_fifo (
    .clk_i, .rst_ni, .wr_i(q_wr), .wdata_i(q_wdata), .rd_i(q_rd),
    .rdata_o(out_item_o), .empty_o(empty), .count_o(cnt)
  );

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> (stage_n_q - stage_rd_q) <= 2'd1)
    else $error("byte accepted over undrained results");
  assert property (@(posedge clk_i) disable iff (!rst_ni) acc && n == 2'd0 |=> stage_n_q == '0)
    else $error("staging count wrong");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt <= QDepth)
    else $error("queue count out of range");
`endif
endmodule
`default_nettype wire
